// ===== sv/src_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_pkg
// shared types and constants for the systematic resampling counter
// ----------------------------------------------------------------------------
package src_pkg;

    localparam int CNT_W   = 17;
    localparam int OFF_W   = 32;
    localparam int LW_W    = 32;
    localparam int IDX_W   = 16;
    localparam int CDF_W   = 49;
    localparam int WGT_W   = 51;
    localparam int SUM_W   = 34;
    localparam int TERM_W  = 33;
    localparam int K_W     = 10;
    localparam int EXP_TERMS = 12;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [CDF_W-1:0] CDF_MAX = {CDF_W{1'b1}};

    localparam logic REG_PARTICLE_COUNT = 1'b0;
    localparam logic REG_OFFSET         = 1'b1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LOG,
        F_LN2,
        F_MUL,
        F_DIV,
        F_SCALE,
        F_SHIFT
    } front_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/src_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_front
// fixed-point exp of the log weight, scaled by the particle count
// ----------------------------------------------------------------------------
module src_front import src_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [LW_W-1:0]      log_weight,
    input  logic [CNT_W-1:0]     n_eff,
    input  q_status_t            q_stat,
    output logic                 q_push,
    output logic [WGT_W-1:0]     q_data
);

    front_state_t state_reg, state_next;

    logic signed [LW_W-1:0] x_reg;
    logic [31:0]            f_reg;
    logic signed [K_W-1:0]  k_reg;
    logic [31:0]            y_reg;
    logic [TERM_W-1:0]      term_reg;
    logic [31:0]            prod_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [3:0]             i_reg;
    logic [WGT_W-1:0]       v_reg;

    logic signed [63:0]     log_prod;
    logic [63:0]            ln_prod;
    logic [63:0]            term_prod;
    logic [WGT_W-1:0]       scale_prod;
    logic [31:0]            rcp;
    logic [5:0]             rsh;
    logic [63:0]            rcp_prod;
    logic [TERM_W-1:0]      quot;
    logic [K_W-1:0]         nk;
    logic [5:0]             sh;
    logic [WGT_W-1:0]       w;

    assign log_prod   = x_reg * LOG2E_Q30;
    assign ln_prod    = f_reg * LN2_Q32;
    assign term_prod  = term_reg * y_reg;
    assign scale_prod = sum_reg * n_eff;
    assign rcp_prod   = prod_reg * rcp;
    assign quot       = TERM_W'(rcp_prod >> rsh);

    // constant divide by reciprocal multiply, exact for the bounded terms
    always_comb begin
        unique case (i_reg)
            4'd2:    begin rcp = 32'h8000_0000; rsh = 6'd32; end
            4'd3:    begin rcp = 32'hAAAA_AAAB; rsh = 6'd33; end
            4'd4:    begin rcp = 32'h4000_0000; rsh = 6'd32; end
            4'd5:    begin rcp = 32'hCCCC_CCCD; rsh = 6'd34; end
            4'd6:    begin rcp = 32'hAAAA_AAAB; rsh = 6'd34; end
            4'd7:    begin rcp = 32'h9249_2493; rsh = 6'd34; end
            4'd8:    begin rcp = 32'h2000_0000; rsh = 6'd32; end
            4'd9:    begin rcp = 32'hE38E_38E4; rsh = 6'd35; end
            4'd10:   begin rcp = 32'hCCCC_CCCD; rsh = 6'd35; end
            4'd11:   begin rcp = 32'hBA2E_8BA3; rsh = 6'd35; end
            4'd12:   begin rcp = 32'hAAAA_AAAB; rsh = 6'd35; end
            default: begin rcp = 32'h8000_0000; rsh = 6'd31; end
        endcase
    end

    // power-of-two scaling with saturation and underflow
    always_comb begin
        nk = -k_reg;
        sh = k_reg[5:0];
        w  = '0;
        if (!k_reg[K_W-1]) begin
            if (k_reg >= K_W'(49)) begin
                w = WGT_W'(CDF_MAX);
            end else if ((v_reg >> (6'd49 - sh)) != '0) begin
                w = WGT_W'(CDF_MAX);
            end else begin
                w = (v_reg << sh) & WGT_W'(CDF_MAX);
            end
        end else if (nk < K_W'(64)) begin
            w = v_reg >> nk[5:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (s_tvalid) state_next = F_LOG;
            F_LOG:   state_next = F_LN2;
            F_LN2:   state_next = F_MUL;
            F_MUL:   state_next = F_DIV;
            F_DIV:   state_next = (i_reg == 4'(EXP_TERMS)) ? F_SCALE : F_MUL;
            F_SCALE: state_next = F_SHIFT;
            F_SHIFT: if (!q_stat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == F_IDLE);
        q_push   = (state_reg == F_SHIFT) && !q_stat.full;
        q_data   = w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) x_reg <= log_weight;
            end
            F_LOG: begin
                f_reg <= log_prod[53:22];
                k_reg <= log_prod[63:54];
            end
            F_LN2: begin
                y_reg    <= ln_prod[63:32];
                term_reg <= TERM_W'(64'h1_0000_0000);
                sum_reg  <= SUM_W'(64'h1_0000_0000);
                i_reg    <= 4'd1;
            end
            F_MUL: begin
                prod_reg <= term_prod[63:32];
            end
            F_DIV: begin
                term_reg <= quot;
                sum_reg  <= sum_reg + SUM_W'(quot);
                i_reg    <= i_reg + 4'd1;
            end
            F_SCALE: begin
                v_reg <= scale_prod;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/src_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_queue
// two-entry queue of scaled weights between front and back
// ----------------------------------------------------------------------------
module src_queue import src_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [WGT_W-1:0]   push_data,
    input  logic               pop,
    output logic [WGT_W-1:0]   pop_data,
    output q_status_t          stat
);

    logic [WGT_W-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== sv/src_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_back
// cumulative sum, offspring count and pass tracking
// ----------------------------------------------------------------------------
module src_back import src_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  q_status_t          q_stat,
    input  logic [WGT_W-1:0]   q_data,
    output logic               q_pop,
    input  logic [CNT_W-1:0]   n_eff,
    input  logic [OFF_W-1:0]   offset,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CNT_W-1:0]   copies,
    output logic [IDX_W-1:0]   particle_index,
    output logic               pass_end
);

    logic [CDF_W-1:0] cdf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             vld_reg;
    logic [CNT_W-1:0] copies_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             last_reg;

    logic [WGT_W:0]   cdf_sum;
    logic [CDF_W-1:0] cdf_new;
    logic [WGT_W-1:0] g_new_full, g_old_full;
    logic [18:0]      g_new, g_old, diff;
    logic [CNT_W-1:0] copies_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             last_next;

    assign q_pop = !q_stat.empty && (!vld_reg || m_tready);

    always_comb begin
        cdf_sum    = {{(WGT_W+1-CDF_W){1'b0}}, cdf_reg} + {1'b0, q_data};
        cdf_new    = (cdf_sum > (WGT_W+1)'(CDF_MAX)) ? CDF_MAX : cdf_sum[CDF_W-1:0];
        g_new_full = WGT_W'(cdf_new) + WGT_W'(64'h2_0000_0000) - WGT_W'(offset) - WGT_W'(1);
        g_old_full = WGT_W'(cdf_reg) + WGT_W'(64'h2_0000_0000) - WGT_W'(offset) - WGT_W'(1);
        g_new      = g_new_full[WGT_W-1:32];
        g_old      = g_old_full[WGT_W-1:32];
        diff       = g_new - g_old;
        copies_next = (diff > 19'(n_eff)) ? n_eff : diff[CNT_W-1:0];
        cnt_inc    = cnt_reg + CNT_W'(1);
        last_next  = (cnt_inc >= n_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cdf_reg <= '0;
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                vld_reg <= 1'b1;
                cdf_reg <= last_next ? '0 : cdf_new;
                cnt_reg <= last_next ? '0 : cnt_inc;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            copies_reg <= copies_next;
            idx_reg    <= cnt_reg[IDX_W-1:0];
            last_reg   <= last_next;
        end
    end

    assign m_tvalid       = vld_reg;
    assign copies         = copies_reg;
    assign particle_index = idx_reg;
    assign pass_end       = last_reg;

    a_copies_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> copies_reg <= n_eff)
        else $error("copies above particle count");

    a_pass_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && last_next) |=> (cnt_reg == '0 && cdf_reg == '0))
        else $error("pass did not restart");

    a_cdf_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (cdf_reg == '0))
        else $error("sum not cleared at pass start");

endmodule

// ===== sv/systematic_resampling_counts.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systematic_resampling_counts
// offspring counts for systematic resampling of a particle filter
// ----------------------------------------------------------------------------
// one signed q8.24 log weight enters per s_ word; one m_ word leaves per
// particle with its offspring count and index, tlast on the pass's last one.
// the front sequencer evaluates exp with one multiplier step per cycle: it
// accepts a weight, forms the log2(e) and ln2 products, computes the twelve
// series terms (multiply, then reciprocal divide), scales by the count and
// shifts; it takes no new weight until it has pushed the last. the back adds
// to the cumulative sum and forms the count combinationally and registers it
// on a queue pop. a two-word queue parts front and back, so a stalled
// receiver holds the back while the front still finishes the next weight.
// the user must write registers through cfg_we, cfg_addr and cfg_data only
// while idle; the block itself does not enforce this. reset clears the sum
// and the index, sets the particle count to 1024 and the offset to one half.
// ----------------------------------------------------------------------------
module systematic_resampling_counts import src_pkg::*; #(
    parameter int MAX_PARTICLES = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // log_weight
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // copies, particle_index, zero pad
    output logic         m_tlast    // pass_end
);

    logic [CNT_W-1:0] pc_reg;
    logic [OFF_W-1:0] off_reg;
    logic [CNT_W-1:0] n_eff;
    q_status_t        q_stat;
    logic             q_push, q_pop;
    logic [WGT_W-1:0] q_wdata, q_rdata;
    logic [CNT_W-1:0] copies;
    logic [IDX_W-1:0] particle_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= CNT_W'(1024);
            off_reg <= 32'h8000_0000;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PARTICLE_COUNT: pc_reg  <= cfg_data[CNT_W-1:0];
                REG_OFFSET:         off_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pc_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(pc_reg) > 32'(MAX_PARTICLES)) begin
            n_eff = CNT_W'(MAX_PARTICLES);
        end else begin
            n_eff = pc_reg;
        end
    end

    src_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .log_weight (s_tdata),
        .n_eff      (n_eff),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    src_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    src_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .n_eff          (n_eff),
        .offset         (off_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .copies         (copies),
        .particle_index (particle_index),
        .pass_end       (m_tlast)
    );

    assign m_tdata = {7'b0, particle_index, copies};

endmodule
